// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions of the double-ended queue
// Sizes, command classes and ring index helpers used by the front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     front_end;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(CAPACITY - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    if (i == '0) begin
      return IDX_W'(CAPACITY - 1);
    end
    return i - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(CAPACITY)) begin
      s = s - (CNT_W + 1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front: command intake
// Accepts items, classifies the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_front
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic signed [DATA_W-1:0] value,
  output      logic                     cmd_valid,
  output      cmd_t                     cmd,
  input  wire logic                     cmd_take
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  cmd_t              incoming;
  logic              push;

  assign incoming.kind      = mode[2:1];
  assign incoming.front_end = ~mode[0];
  assign incoming.value     = value;

  assign in_stall  = rst || (fill == (QPTR_W + 1)'(QDEPTH));
  assign push      = in_valid && !in_stall && (incoming.kind != KIND_NONE);
  assign cmd_valid = (fill != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, cmd_take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back: command execution
// Holds the ring pointers and the entry RAM, runs pushes, pops and dumps,
// and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_back
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  input  wire cmd_t                     cmd,
  output      logic                     cmd_take,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic signed [DATA_W-1:0] out_value,
  output      logic                     queue_empty,
  output      logic                     dropped,
  output      logic                     last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic              state, state_next;
  logic [IDX_W-1:0]  front_pos, front_pos_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic [IDX_W-1:0]  rp, rp_next;
  logic              fwd, fwd_next;

  logic              out_valid_next;
  logic [DATA_W-1:0] out_value_next;
  logic              queue_empty_next;
  logic              dropped_next;
  logic              last_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  logic              full;
  logic              empty;
  logic              out_free;
  logic              needs_out;

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign out_free  = !out_valid || !out_stall;
  assign needs_out = ((cmd.kind == KIND_PUSH) && full) || ((cmd.kind == KIND_DUMP) && empty);
  assign cmd_take  = (state == S_IDLE) && cmd_valid && (!needs_out || out_free);

  always_comb begin
    state_next       = state;
    front_pos_next   = front_pos;
    count_next       = count;
    remain_next      = remain;
    rp_next          = rp;
    fwd_next         = fwd;
    out_valid_next   = out_valid && out_stall;
    out_value_next   = out_value;
    queue_empty_next = queue_empty;
    dropped_next     = dropped;
    last_next        = last;
    we               = 1'b0;
    waddr            = front_pos;
    re               = 1'b0;
    raddr            = rp;

    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.kind)
            KIND_PUSH: begin
              if (full) begin
                out_valid_next   = 1'b1;
                out_value_next   = '0;
                queue_empty_next = 1'b0;
                dropped_next     = 1'b1;
                last_next        = 1'b1;
              end else begin
                we = 1'b1;
                if (cmd.front_end) begin
                  waddr          = wrap_dec(front_pos);
                  front_pos_next = wrap_dec(front_pos);
                end else begin
                  waddr = ring_add(front_pos, count);
                end
                count_next = count + 1'b1;
              end
            end
            KIND_POP: begin
              if (!empty) begin
                count_next = count - 1'b1;
                if (cmd.front_end) begin
                  front_pos_next = wrap_inc(front_pos);
                end
              end
            end
            KIND_DUMP: begin
              if (empty) begin
                out_valid_next   = 1'b1;
                out_value_next   = '0;
                queue_empty_next = 1'b1;
                dropped_next     = 1'b0;
                last_next        = 1'b1;
              end else begin
                re          = 1'b1;
                raddr       = cmd.front_end ? front_pos : ring_add(front_pos, count - 1'b1);
                rp_next     = cmd.front_end ? wrap_inc(raddr) : wrap_dec(raddr);
                remain_next = count;
                fwd_next    = cmd.front_end;
                state_next  = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_value_next   = rdata;
          queue_empty_next = 1'b0;
          dropped_next     = 1'b0;
          last_next        = (remain == CNT_W'(1));
          remain_next      = remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = rp;
            rp_next = fwd ? wrap_inc(rp) : wrap_dec(rp);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    remain      <= remain_next;
    rp          <= rp_next;
    fwd         <= fwd_next;
    out_value   <= $signed(out_value_next);
    queue_empty <= queue_empty_next;
    dropped     <= dropped_next;
    last        <= last_next;
    if (rst) begin
      state     <= S_IDLE;
      front_pos <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front_pos <= front_pos_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// Channel   Handshake             Payload
// input     in_valid / in_stall   mode, value
// output    out_valid / out_stall out_value, queue_empty, dropped, last
//
// Push and pop items are executed by the back end as it takes them. A dump
// of n entries is paced by the single registered read port of the entry
// RAM. A drop report or an empty dump gives a single zero result.
// A two-entry command queue lets input be taken while a result waits.
// Reset does not clear the entry RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic signed [DATA_W-1:0] value,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic signed [DATA_W-1:0] out_value,
  output      logic                     queue_empty,
  output      logic                     dropped,
  output      logic                     last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  deq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .value    (value),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  deq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .queue_empty(queue_empty),
    .dropped    (dropped),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches both channels and the reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic [MODE_W-1:0]        mode,
  input wire logic signed [DATA_W-1:0] value,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [DATA_W-1:0] out_value,
  input wire logic                     queue_empty,
  input wire logic                     dropped,
  input wire logic                     last
);

  a_reset_clears: assert property (@(posedge clk) rst |-> in_stall ##1 !out_valid)
    else $error("Input open during reset or result valid right after reset.");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(mode) && $stable(value))
    else $error("Stalled input item changed.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(last))
    else $error("Stalled result changed.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(queue_empty && dropped))
    else $error("Empty and dropped flagged together.");

  a_flag_is_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (queue_empty || dropped) |-> last && (out_value == '0))
    else $error("Flagged result is not a single zero result.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .mode       (mode),
  .value      (value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_value  (out_value),
  .queue_empty(queue_empty),
  .dropped    (dropped),
  .last       (last)
);

`default_nettype wire
